>>> hdl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and codes for the bracket pair matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package bpm_pkg;

    localparam int FIELD_BITS = 16;
    localparam int LEFT_BITS  = 7;

    typedef enum logic [1:0] {
        REQ_OPEN  = 2'd0,
        REQ_CLOSE = 2'd1,
        REQ_END   = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NO_OPENER = 2'd1,
        ERR_UNCLOSED  = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } err_code_t;

    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result under way between the control stage and the response stage
    typedef struct packed {
        logic                   valid;
        logic                   use_mem;
        logic                   kind;
        err_code_t              err;
        logic [FIELD_BITS-1:0]  slot;
        logic [FIELD_BITS-1:0]  open_pos;
        logic [FIELD_BITS-1:0]  close_pos;
        logic [LEFT_BITS-1:0]   open_left;
    } bpm_stage_t;

endpackage

`default_nettype wire

>>> hdl/bpm_req_if.sv
// ----------------------------------------------------------------------------
// bpm_req_if
// Token event channel: request type and character position.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] position;

    modport source (output valid, output req_type, output position, input ready);
    modport sink   (input valid, input req_type, input position, output ready);
endinterface

`default_nettype wire

>>> hdl/bpm_rsp_if.sv
// ----------------------------------------------------------------------------
// bpm_rsp_if
// Result channel: matched pairs, closer errors, overflow and end status.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpm_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] slot;
    logic [15:0] open_pos;
    logic [15:0] close_pos;
    logic [1:0]  error_code;
    logic [6:0]  open_left;

    modport source (output valid, output result_kind, output slot, output open_pos,
                    output close_pos, output error_code, output open_left,
                    input ready);
    modport sink   (input valid, input result_kind, input slot, input open_pos,
                    input close_pos, input error_code, input open_left,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/bpm_stack_mem.sv
// ----------------------------------------------------------------------------
// bpm_stack_mem
// Stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_stack_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/bpm_ctrl.sv
// ----------------------------------------------------------------------------
// bpm_ctrl
// Stack pointer, slot counter and overflow flag; issues pushes and pops.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_ctrl #(
    parameter int STACK_DEPTH = 64,
    parameter int PW          = 16,
    parameter int AW          = 6,
    parameter int SPW         = 7
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    bpm_req_if.sink                 req,
    input  wire logic               stage_ready,
    output bpm_pkg::bpm_stage_t     stage_in,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output logic [bpm_pkg::FIELD_BITS+PW-1:0] mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr
);

    logic [SPW-1:0]                 sp_reg, sp_next;
    logic [bpm_pkg::FIELD_BITS-1:0] slot_reg, slot_next;
    logic                           ovf_reg, ovf_next;

    logic                           fire;
    logic [PW-1:0]                  pos_kept;
    logic [bpm_pkg::FIELD_BITS-1:0] pos16;
    logic [SPW-1:0]                 sp_dec;
    logic [31:0]                    sp_wide;
    logic [bpm_pkg::LEFT_BITS-1:0]  left_sat;
    logic                           stack_full;

    assign req.ready  = stage_ready;
    assign fire       = req.valid & stage_ready;
    assign pos_kept   = req.position[PW-1:0];
    assign pos16      = bpm_pkg::FIELD_BITS'(pos_kept);
    assign sp_dec     = sp_reg - SPW'(1);
    assign sp_wide    = 32'(sp_reg);
    assign left_sat   = (sp_wide > 32'd127) ? 7'd127 : sp_wide[6:0];
    assign stack_full = (sp_reg == SPW'(STACK_DEPTH));

    assign mem_waddr  = sp_reg[AW-1:0];
    assign mem_wdata  = {slot_reg, pos_kept};
    assign mem_raddr  = sp_dec[AW-1:0];

    always_comb
    begin
        sp_next   = sp_reg;
        slot_next = slot_reg;
        ovf_next  = ovf_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        stage_in           = '0;
        stage_in.kind      = bpm_pkg::KIND_PAIR;
        stage_in.err       = bpm_pkg::ERR_NONE;
        stage_in.close_pos = pos16;
        if (fire)
        begin
            unique case (req.req_type)
                bpm_pkg::REQ_OPEN:
                begin
                    if (stack_full)
                    begin
                        // drop the opener, report it and remember the loss
                        ovf_next           = 1'b1;
                        stage_in.valid     = 1'b1;
                        stage_in.err       = bpm_pkg::ERR_OVERFLOW;
                        stage_in.open_pos  = pos16;
                        stage_in.close_pos = '0;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        sp_next   = sp_reg + SPW'(1);
                        slot_next = slot_reg + 16'd1;
                    end
                end
                bpm_pkg::REQ_CLOSE:
                begin
                    stage_in.valid = 1'b1;
                    if (sp_reg == '0)
                    begin
                        stage_in.err = bpm_pkg::ERR_NO_OPENER;
                    end
                    else
                    begin
                        // slot and open position come from the read data next cycle
                        mem_re           = 1'b1;
                        stage_in.use_mem = 1'b1;
                        sp_next          = sp_dec;
                    end
                end
                bpm_pkg::REQ_END:
                begin
                    stage_in.valid     = 1'b1;
                    stage_in.kind      = bpm_pkg::KIND_END;
                    stage_in.slot      = slot_reg;
                    stage_in.open_left = left_sat;
                    if (sp_reg != '0)
                    begin
                        stage_in.err = bpm_pkg::ERR_UNCLOSED;
                    end
                    else if (ovf_reg)
                    begin
                        stage_in.err = bpm_pkg::ERR_OVERFLOW;
                    end
                    sp_next   = '0;
                    slot_next = '0;
                    ovf_next  = 1'b0;
                end
                default:
                begin
                    // unknown request: drop it
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            slot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            sp_reg   <= sp_next;
            slot_reg <= slot_next;
            ovf_reg  <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.req_type == bpm_pkg::REQ_END |=> sp_reg == '0 && slot_reg == '0 && !ovf_reg)
        else $error("end mark did not clear the state");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.req_type == bpm_pkg::REQ_OPEN && !stack_full
        |=> sp_reg == $past(sp_reg) + SPW'(1) && slot_reg == $past(slot_reg) + 16'd1)
        else $error("push did not advance pointer and slot");

    a_pop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("push and pop issued together");
`endif

endmodule

`default_nettype wire

>>> hdl/bpm_resp.sv
// ----------------------------------------------------------------------------
// bpm_resp
// Read-data stage and output register; merges popped entries into results.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_resp #(
    parameter int PW = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bpm_pkg::bpm_stage_t                 stage_in,
    output logic                                     stage_ready,
    input  wire logic [bpm_pkg::FIELD_BITS+PW-1:0]   mem_rdata,
    bpm_rsp_if.source                                rsp
);

    bpm_pkg::bpm_stage_t            s1_reg, s1_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           kind_reg;
    logic [bpm_pkg::FIELD_BITS-1:0] slot_reg, open_reg, close_reg;
    logic [1:0]                     err_reg;
    logic [bpm_pkg::LEFT_BITS-1:0]  left_reg;

    logic                           out_free;
    logic                           move;
    logic [bpm_pkg::FIELD_BITS-1:0] slot_sel, open_sel;

    assign out_free    = !out_valid_reg || rsp.ready;
    assign stage_ready = !s1_reg.valid || out_free;
    assign move        = s1_reg.valid && out_free;

    assign slot_sel = s1_reg.use_mem ? mem_rdata[PW +: bpm_pkg::FIELD_BITS] : s1_reg.slot;
    assign open_sel = s1_reg.use_mem ? bpm_pkg::FIELD_BITS'(mem_rdata[PW-1:0])
                                     : s1_reg.open_pos;

    always_comb
    begin
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg;
        if (stage_ready)
        begin
            s1_next = stage_in;
        end
        if (out_free)
        begin
            out_valid_next = move;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= s1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: load on advance, hold while the sink stalls
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            kind_reg  <= s1_reg.kind;
            slot_reg  <= slot_sel;
            open_reg  <= open_sel;
            close_reg <= s1_reg.close_pos;
            err_reg   <= s1_reg.err;
            left_reg  <= s1_reg.open_left;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = kind_reg;
    assign rsp.slot        = slot_reg;
    assign rsp.open_pos    = open_reg;
    assign rsp.close_pos   = close_reg;
    assign rsp.error_code  = err_reg;
    assign rsp.open_left   = left_reg;

`ifndef SYNTHESIS
    a_mem_pair_only: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && s1_reg.use_mem |-> s1_reg.kind == bpm_pkg::KIND_PAIR
            && s1_reg.err == bpm_pkg::ERR_NONE)
        else $error("popped entry attached to a non-pair result");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && !out_free |=> s1_reg.valid && $stable(s1_reg))
        else $error("pending stage lost while output stalled");

    a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("advanced result did not reach the output");
`endif

endmodule

`default_nettype wire

>>> hdl/bracket_pair_matcher.sv
// ----------------------------------------------------------------------------
// bracket_pair_matcher
// Pairs group openers with closers in text order on a memory-based stack.
// ----------------------------------------------------------------------------
// Usage:
//   req carries token events (opener, closer, end of text) with a position.
//   rsp carries one transaction per closer, per dropped opener and per end
//   mark: matched pair, closer without opener, overflow, or end status.
//   Accepted openers produce no transaction; unknown request types are dropped.
//   Path: a taken request is registered in the read-data stage along with
//   the stack memory read, then moves into the output register.
//   Throughput: one request per cycle while req.ready is high, set by the
//   stack pointer update and one memory port per direction.
//   Stall: req.ready falls only when both the read-data stage and the output
//   register hold results and rsp.ready is low; the output holds steady.
//   Reset: pointer, slot counter and overflow flag clear at once; the stack
//   memory needs no clearing, as only entries below the pointer are read.
//   An end mark clears the same state, ready for the next text.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_pair_matcher #(
    parameter int STACK_DEPTH = 64,
    parameter int POS_BITS    = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bpm_req_if.sink    req,
    bpm_rsp_if.source  rsp
);

    localparam int PW  = (POS_BITS < bpm_pkg::FIELD_BITS) ? POS_BITS : bpm_pkg::FIELD_BITS;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int MW  = bpm_pkg::FIELD_BITS + PW;

    bpm_pkg::bpm_stage_t stage_in;
    logic                stage_ready;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [MW-1:0]       mem_rdata;

    bpm_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .PW          (PW),
        .AW          (AW),
        .SPW         (SPW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .stage_ready (stage_ready),
        .stage_in    (stage_in),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr)
    );

    bpm_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (MW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bpm_resp #(
        .PW (PW)
    ) u_resp (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_in    (stage_in),
        .stage_ready (stage_ready),
        .mem_rdata   (mem_rdata),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

>>> verif/bracket_pair_matcher_tb.sv
// ----------------------------------------------------------------------------
// bracket_pair_matcher_tb
// Drives token events into the bracket pair matcher and checks every result
// transaction against a shadow stack kept in the testbench. Directed tests
// cover closers without openers, nesting, position extremes and unclosed
// groups. Random texts then mix well-formed nesting, noise and bursts that
// overrun the stack, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_pair_matcher_tb;

    localparam int STACK_DEPTH = 64;
    localparam int POS_BITS    = 16;
    localparam int RANDOM_ITEMS = 1450;
    localparam int IDLE_PERCENT = 24;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [15:0] POS_MASK = 16'((64'd1 << POS_BITS) - 1);

    typedef struct packed {
        logic                           kind;
        logic [bpm_pkg::FIELD_BITS-1:0] slot;
        logic [bpm_pkg::FIELD_BITS-1:0] open_pos;
        logic [bpm_pkg::FIELD_BITS-1:0] close_pos;
        logic [1:0]                     err;
        logic [bpm_pkg::LEFT_BITS-1:0]  open_left;
    } pair_result_t;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   fail_count;
    int   items_sent;

    // Shadow of the matcher state
    logic [15:0] shadow_slot [STACK_DEPTH];
    logic [15:0] shadow_pos  [STACK_DEPTH];
    int          open_depth;
    logic [15:0] next_slot_no;
    logic        overflow_flag;

    pair_result_t pending_results [$];

    bpm_req_if req_if ();
    bpm_rsp_if rsp_if ();

    bracket_pair_matcher #(
        .STACK_DEPTH (STACK_DEPTH),
        .POS_BITS    (POS_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 50)
        begin
            $display("MISMATCH at %0t: %s got %0h, expected %0h", $time, field, got, want);
        end
    endtask

    // Append one expected result to the tail of the queue
    function automatic void queue_expected(input pair_result_t res);
        pending_results = {pending_results, res};
    endfunction

    function automatic void predict_matcher(input logic [1:0] token, input logic [15:0] pos);
        pair_result_t res;
        logic [15:0]  kept;
        res  = '0;
        kept = pos & POS_MASK;
        case (token)
            bpm_pkg::REQ_OPEN:
            begin
                if (open_depth >= STACK_DEPTH)
                begin
                    // Drop the opener; it takes no slot
                    overflow_flag = 1'b1;
                    res.kind      = bpm_pkg::KIND_PAIR;
                    res.open_pos  = kept;
                    res.err       = bpm_pkg::ERR_OVERFLOW;
                    queue_expected(res);
                end
                else
                begin
                    shadow_slot[open_depth] = next_slot_no;
                    shadow_pos[open_depth]  = kept;
                    open_depth++;
                    next_slot_no++;
                end
            end
            bpm_pkg::REQ_CLOSE:
            begin
                res.kind      = bpm_pkg::KIND_PAIR;
                res.close_pos = kept;
                if (open_depth == 0)
                begin
                    res.err = bpm_pkg::ERR_NO_OPENER;
                end
                else
                begin
                    open_depth--;
                    res.slot     = shadow_slot[open_depth];
                    res.open_pos = shadow_pos[open_depth];
                    res.err      = bpm_pkg::ERR_NONE;
                end
                queue_expected(res);
            end
            bpm_pkg::REQ_END:
            begin
                res.kind      = bpm_pkg::KIND_END;
                res.slot      = next_slot_no;
                res.close_pos = kept;
                res.open_left = (open_depth > 127) ? 7'd127 : 7'(open_depth);
                if (open_depth != 0)
                    res.err = bpm_pkg::ERR_UNCLOSED;
                else if (overflow_flag)
                    res.err = bpm_pkg::ERR_OVERFLOW;
                else
                    res.err = bpm_pkg::ERR_NONE;
                queue_expected(res);
                open_depth    = 0;
                next_slot_no  = '0;
                overflow_flag = 1'b0;
            end
            default:
            begin
                // Unknown request type: no effect
            end
        endcase
    endfunction

    // Present one token and hold it until the transaction completes
    task automatic send_token(input logic [1:0] token, input logic [15:0] pos);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= token;
        req_if.position <= pos;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_matcher(token, pos);
        if (token != REQ_UNUSED)
            items_sent++;
    endtask

    function automatic logic [15:0] random_position();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return 16'h0000;
        else if (pick < 16)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // Checker and result-side back-pressure
    always @(posedge clk)
    begin
        pair_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected, close_pos",
                                32'(rsp_if.close_pos), 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.result_kind !== want.kind)
                    report_mismatch("result_kind", 32'(rsp_if.result_kind), 32'(want.kind));
                if (rsp_if.slot !== want.slot)
                    report_mismatch("slot", 32'(rsp_if.slot), 32'(want.slot));
                if (rsp_if.open_pos !== want.open_pos)
                    report_mismatch("open_pos", 32'(rsp_if.open_pos), 32'(want.open_pos));
                if (rsp_if.close_pos !== want.close_pos)
                    report_mismatch("close_pos", 32'(rsp_if.close_pos), 32'(want.close_pos));
                if (rsp_if.error_code !== want.err)
                    report_mismatch("error_code", 32'(rsp_if.error_code), 32'(want.err));
                if (rsp_if.open_left !== want.open_left)
                    report_mismatch("open_left", 32'(rsp_if.open_left), 32'(want.open_left));
            end
        end
        rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    task automatic test_closer_without_opener();
        send_token(bpm_pkg::REQ_CLOSE, 16'h0000);
        send_token(bpm_pkg::REQ_CLOSE, 16'hFFFF);
        send_token(bpm_pkg::REQ_END,   16'h0000);
    endtask

    task automatic test_nested_pairs();
        send_token(bpm_pkg::REQ_OPEN,  16'h0000);
        send_token(bpm_pkg::REQ_OPEN,  16'hFFFF);
        send_token(REQ_UNUSED,         16'h5555);
        send_token(bpm_pkg::REQ_OPEN,  16'h1234);
        send_token(bpm_pkg::REQ_CLOSE, 16'hAAAA);
        send_token(bpm_pkg::REQ_CLOSE, 16'h5555);
        send_token(bpm_pkg::REQ_CLOSE, 16'hFFFF);
        send_token(bpm_pkg::REQ_END,   16'hFFFF);
    endtask

    task automatic test_unclosed_at_end();
        send_token(bpm_pkg::REQ_OPEN,  16'h0001);
        send_token(bpm_pkg::REQ_OPEN,  16'h8000);
        send_token(bpm_pkg::REQ_CLOSE, 16'h7FFF);
        send_token(bpm_pkg::REQ_END,   16'h00FF);
        // Slot numbering restarts after the end mark
        send_token(bpm_pkg::REQ_OPEN,  16'h0002);
        send_token(bpm_pkg::REQ_CLOSE, 16'h0003);
        send_token(bpm_pkg::REQ_END,   16'h0004);
    endtask

    task automatic test_random_texts();
        int text_index;
        int deep_count;
        int len;
        int depth;
        int pops;
        text_index = 0;
        deep_count = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            no_idle = (text_index >= 20 && text_index < 30);
            if (text_index % 12 == 0)
            begin
                // Overrun the stack, then unwind fully or partly
                len = STACK_DEPTH + $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_token(bpm_pkg::REQ_OPEN, random_position());
                pops = (deep_count % 2 == 0) ? STACK_DEPTH + $urandom_range(0, 1)
                                             : $urandom_range(0, STACK_DEPTH);
                for (int i = 0; i < pops; i++)
                    send_token(bpm_pkg::REQ_CLOSE, random_position());
                send_token(bpm_pkg::REQ_END, random_position());
                deep_count++;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                // Noise: any request type in any order
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    send_token(2'($urandom_range(0, 3)), random_position());
                if ($urandom_range(0, 1))
                    send_token(bpm_pkg::REQ_END, random_position());
            end
            else
            begin
                len   = $urandom_range(1, 40);
                depth = 0;
                for (int i = 0; i < len; i++)
                begin
                    if (depth == 0 || (depth < 20 && $urandom_range(0, 1)))
                    begin
                        send_token(bpm_pkg::REQ_OPEN, random_position());
                        depth++;
                    end
                    else
                    begin
                        send_token(bpm_pkg::REQ_CLOSE, random_position());
                        depth--;
                    end
                end
                if ($urandom_range(0, 99) < 75)
                begin
                    while (depth > 0)
                    begin
                        send_token(bpm_pkg::REQ_CLOSE, random_position());
                        depth--;
                    end
                end
                send_token(bpm_pkg::REQ_END, random_position());
            end
            text_index++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int drain_wait;
        clk             = 1'b0;
        rst_n           = 1'b0;
        no_idle         = 1'b0;
        fail_count      = 0;
        items_sent      = 0;
        open_depth      = 0;
        next_slot_no    = '0;
        overflow_flag   = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = bpm_pkg::REQ_OPEN;
        req_if.position = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_closer_without_opener();
        test_nested_pairs();
        test_unclosed_at_end();
        test_random_texts();
        req_if.valid <= 1'b0;

        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < 5000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        // Allow any result still in the pipeline to surface
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("expected results left over", 32'(pending_results.size()), 32'd0);

        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
